@@ hdl/assert_macros.svh @@
// assertion macros used by the sequencer rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ALTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ALTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/alte_pkg.sv @@
// package of the array list table engine: widths, operation codes, result type
`timescale 1ns / 1ps
package alte_pkg;
  localparam int Depth = 64;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = IdxW + 1;
  localparam int DataW = 32;

  localparam logic [3:0] OP_APPEND  = 4'd0;
  localparam logic [3:0] OP_INSERT  = 4'd1;
  localparam logic [3:0] OP_DELETE  = 4'd2;
  localparam logic [3:0] OP_GET     = 4'd3;
  localparam logic [3:0] OP_SET     = 4'd4;
  localparam logic [3:0] OP_LSEARCH = 4'd5;
  localparam logic [3:0] OP_SINSERT = 4'd6;
  localparam logic [3:0] OP_BSEARCH = 4'd7;
  localparam logic [3:0] OP_STATS   = 4'd8;
  localparam logic [3:0] OP_REVERSE = 4'd9;
  localparam logic [3:0] OP_PART    = 4'd10;
  localparam logic [3:0] OP_SORTED  = 4'd11;

  typedef struct packed {
    logic             in_order;
    logic [CntW-1:0]  entry_count;
    logic [DataW-1:0] smallest;
    logic [DataW-1:0] largest;
    logic [DataW-1:0] total_sum;
    logic [DataW-1:0] result_value;
    logic [IdxW-1:0]  result_index;
    logic             found;
    logic             accepted;
  } result_t;

  localparam int ResW = $bits(result_t);
  localparam int OutBytesW = ((ResW + 7) / 8) * 8;
endpackage

@@ hdl/alte_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read per cycle
`timescale 1ns / 1ps
module alte_ram #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/alte_seq.sv @@
// operation sequencer: walks the entry ram, one request at a time
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alte_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [alte_pkg::CntW-1:0]     capacity,
  input  logic                          start,
  input  logic [3:0]                    mode,
  input  logic [alte_pkg::IdxW-1:0]     position,
  input  logic [alte_pkg::DataW-1:0]    data_value,
  input  logic [alte_pkg::DataW-1:0]    search_key,
  output logic                          busy,
  output logic                          done,
  output alte_pkg::result_t             result,
  output logic                          ram_we,
  output logic [alte_pkg::IdxW-1:0]     ram_waddr,
  output logic [alte_pkg::DataW-1:0]    ram_wdata,
  output logic [alte_pkg::IdxW-1:0]     ram_raddr,
  input  logic [alte_pkg::DataW-1:0]    ram_rdata
);
  localparam int IW = alte_pkg::IdxW;
  localparam int CW = alte_pkg::CntW;
  localparam int DW = alte_pkg::DataW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EX   = 5'b00100,
    S_WB   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]    mode_r;
  logic [IW-1:0] pos_r;
  logic [DW-1:0] data_r, key_r;
  logic [CW-1:0] fill_r, fill_nxt;
  // working indices: i walks up (down for the inserts), j walks down (signed to allow -1)
  logic signed [CW:0] i_r, i_nxt, j_r, j_nxt;
  logic [DW-1:0] a_r, a_nxt;     // first value held between accesses
  logic          ph_r, ph_nxt;   // second fetch of a pair
  logic [DW-1:0] sum_r, sum_nxt, mx_r, mx_nxt, mn_r, mn_nxt;
  alte_pkg::result_t res_r, res_nxt;
  logic [CW-1:0] lim;
  logic signed [CW:0] mid;
  logic signed [CW:0] n_s;

  assign lim  = (capacity > CW'(alte_pkg::Depth)) ? CW'(alte_pkg::Depth) : capacity;
  assign n_s  = {1'b0, fill_r};
  assign mid  = (i_r + j_r) >>> 1;
  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_FIN);
  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      pos_r  <= position;
      data_r <= data_value;
      key_r  <= search_key;
    end
    i_r <= i_nxt; j_r <= j_nxt; a_r <= a_nxt; ph_r <= ph_nxt;
    sum_r <= sum_nxt; mx_r <= mx_nxt; mn_r <= mn_nxt; res_r <= res_nxt;
  end

  // S_RD issues the address, S_EX uses ram_rdata in the cycle after
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r;
    i_nxt = i_r; j_nxt = j_r; a_nxt = a_r; ph_nxt = ph_r;
    sum_nxt = sum_r; mx_nxt = mx_r; mn_nxt = mn_r; res_nxt = res_r;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          ph_nxt = 1'b0;
          sum_nxt = '0;
          state_nxt = S_FIN;
          unique case (mode)
            alte_pkg::OP_APPEND: begin
              if (fill_r < lim) begin
                ram_we = 1'b1; ram_waddr = fill_r[IW-1:0]; ram_wdata = data_value;
                fill_nxt = fill_r + 1'b1; res_nxt.accepted = 1'b1;
              end
            end
            alte_pkg::OP_INSERT: begin
              if (fill_r < lim && CW'(position) <= fill_r) begin
                i_nxt = n_s; state_nxt = S_RD;
              end
            end
            alte_pkg::OP_DELETE, alte_pkg::OP_GET: begin
              if (CW'(position) < fill_r) begin
                i_nxt = (CW+1)'(position); state_nxt = S_RD;
              end
            end
            alte_pkg::OP_SET: begin
              if (CW'(position) < fill_r) begin
                ram_we = 1'b1; ram_waddr = position; ram_wdata = data_value;
                res_nxt.accepted = 1'b1;
              end
            end
            alte_pkg::OP_SINSERT: begin
              if (fill_r < lim) begin
                i_nxt = n_s - 2'sd1; state_nxt = S_RD;
              end
            end
            alte_pkg::OP_STATS: begin
              if (fill_r != '0) begin
                i_nxt = '0; state_nxt = S_RD;
              end
            end
            alte_pkg::OP_LSEARCH, alte_pkg::OP_BSEARCH, alte_pkg::OP_REVERSE,
            alte_pkg::OP_PART, alte_pkg::OP_SORTED: begin
              res_nxt.accepted = 1'b1;
              res_nxt.in_order = (mode == alte_pkg::OP_SORTED);
              i_nxt = '0; j_nxt = n_s - 2'sd1; state_nxt = S_RD;
            end
            default: ;
          endcase
          if (state_nxt == S_FIN) res_nxt.entry_count = fill_nxt;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
        unique case (mode_r)
          alte_pkg::OP_INSERT: begin
            if (i_r > (CW+1)'(pos_r)) ram_raddr = IW'(i_r - 2'sd1);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_DELETE: begin
            if (ph_r) begin
              if (i_r + 2'sd1 < n_s) ram_raddr = IW'(i_r + 2'sd1);
              else state_nxt = S_WB;
            end else ram_raddr = IW'(i_r);
          end
          alte_pkg::OP_SINSERT: begin
            if (i_r >= 0) ram_raddr = IW'(i_r);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_STATS: begin
            if (i_r < n_s) ram_raddr = IW'(i_r);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_LSEARCH: begin
            if (ph_r) ram_raddr = '0;
            else if (i_r < n_s) ram_raddr = IW'(i_r);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_BSEARCH: begin
            if (i_r <= j_r) ram_raddr = IW'(mid);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_REVERSE: begin
            if (i_r < j_r) ram_raddr = ph_r ? IW'(j_r) : IW'(i_r);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_PART: begin
            if (i_r < j_r) ram_raddr = ph_r ? IW'(j_r) : IW'(i_r);
            else state_nxt = S_WB;
          end
          alte_pkg::OP_SORTED: begin
            if (i_r + 2'sd1 < n_s) ram_raddr = ph_r ? IW'(i_r + 2'sd1) : IW'(i_r);
            else state_nxt = S_WB;
          end
          default: ram_raddr = IW'(i_r);
        endcase
      end
      S_EX: begin
        state_nxt = S_RD;
        unique case (mode_r)
          alte_pkg::OP_INSERT: begin
            ram_we = 1'b1; ram_waddr = IW'(i_r); ram_wdata = ram_rdata;
            i_nxt = i_r - 2'sd1;
          end
          alte_pkg::OP_DELETE: begin
            if (!ph_r) begin
              res_nxt.result_value = ram_rdata; ph_nxt = 1'b1;
            end else begin
              ram_we = 1'b1; ram_waddr = IW'(i_r); ram_wdata = ram_rdata;
              i_nxt = i_r + 2'sd1;
            end
          end
          alte_pkg::OP_GET: begin
            res_nxt.result_value = ram_rdata; res_nxt.accepted = 1'b1;
            state_nxt = S_FIN; res_nxt.entry_count = fill_r;
          end
          alte_pkg::OP_SINSERT: begin
            if ($signed(ram_rdata) > $signed(data_r)) begin
              ram_we = 1'b1; ram_waddr = IW'(i_r + 2'sd1); ram_wdata = ram_rdata;
              i_nxt = i_r - 2'sd1;
            end else state_nxt = S_WB;
          end
          alte_pkg::OP_STATS: begin
            sum_nxt = sum_r + ram_rdata;
            if (i_r == 0) begin
              mx_nxt = ram_rdata; mn_nxt = ram_rdata;
            end else begin
              if ($signed(ram_rdata) > $signed(mx_r)) mx_nxt = ram_rdata;
              if ($signed(ram_rdata) < $signed(mn_r)) mn_nxt = ram_rdata;
            end
            i_nxt = i_r + 2'sd1;
          end
          alte_pkg::OP_LSEARCH: begin
            if (ph_r) begin
              // a_r holds the hit; put entry 0 at hit index and hit at 0
              ram_we = 1'b1; ram_waddr = res_r.result_index; ram_wdata = ram_rdata;
              a_nxt = a_r; state_nxt = S_WB; ph_nxt = 1'b0;
            end else if (ram_rdata == key_r) begin
              res_nxt.found = 1'b1; res_nxt.result_index = IW'(i_r);
              a_nxt = ram_rdata; ph_nxt = 1'b1;
            end else i_nxt = i_r + 2'sd1;
          end
          alte_pkg::OP_BSEARCH: begin
            if (ram_rdata == key_r) begin
              res_nxt.found = 1'b1; res_nxt.result_index = IW'(mid);
              state_nxt = S_WB;
            end else if ($signed(key_r) < $signed(ram_rdata)) j_nxt = mid - 2'sd1;
            else i_nxt = mid + 2'sd1;
          end
          alte_pkg::OP_REVERSE: begin
            if (!ph_r) begin
              a_nxt = ram_rdata; ph_nxt = 1'b1;
            end else begin
              ram_we = 1'b1; ram_waddr = IW'(i_r); ram_wdata = ram_rdata;
              j_nxt = j_r; ph_nxt = 1'b0; state_nxt = S_WB;
            end
          end
          alte_pkg::OP_PART: begin
            if (!ph_r) begin
              if ($signed(ram_rdata) < 0) i_nxt = i_r + 2'sd1;
              else begin
                a_nxt = ram_rdata; ph_nxt = 1'b1;
              end
            end else begin
              if ($signed(ram_rdata) >= 0) j_nxt = j_r - 2'sd1;
              else begin
                ram_we = 1'b1; ram_waddr = IW'(i_r); ram_wdata = ram_rdata;
                ph_nxt = 1'b0; state_nxt = S_WB;
              end
            end
          end
          alte_pkg::OP_SORTED: begin
            if (!ph_r) begin
              a_nxt = ram_rdata; ph_nxt = 1'b1;
            end else begin
              ph_nxt = 1'b0;
              if ($signed(a_r) > $signed(ram_rdata)) begin
                res_nxt.in_order = 1'b0; state_nxt = S_WB;
              end else i_nxt = i_r + 2'sd1;
            end
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_WB: begin
        // final write or result update of a walk, or second half of a swap
        state_nxt = S_FIN;
        unique case (mode_r)
          alte_pkg::OP_INSERT: begin
            ram_we = 1'b1; ram_waddr = pos_r; ram_wdata = data_r;
            fill_nxt = fill_r + 1'b1; res_nxt.accepted = 1'b1;
          end
          alte_pkg::OP_DELETE: begin
            fill_nxt = fill_r - 1'b1; res_nxt.accepted = 1'b1;
          end
          alte_pkg::OP_SINSERT: begin
            ram_we = 1'b1; ram_waddr = IW'(i_r + 2'sd1); ram_wdata = data_r;
            fill_nxt = fill_r + 1'b1; res_nxt.accepted = 1'b1;
          end
          alte_pkg::OP_STATS: begin
            res_nxt.accepted = 1'b1; res_nxt.total_sum = sum_r;
            res_nxt.largest = mx_r; res_nxt.smallest = mn_r;
          end
          alte_pkg::OP_LSEARCH: begin
            if (res_r.found) begin
              ram_we = 1'b1; ram_waddr = '0; ram_wdata = a_r;
            end
          end
          alte_pkg::OP_REVERSE, alte_pkg::OP_PART: begin
            if (i_r < j_r) begin
              ram_we = 1'b1; ram_waddr = IW'(j_r); ram_wdata = a_r;
              i_nxt = i_r + 2'sd1; j_nxt = j_r - 2'sd1; state_nxt = S_RD;
            end
          end
          default: ;
        endcase
        if (state_nxt == S_FIN) res_nxt.entry_count = fill_nxt;
      end
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  `ALTE_ASSERT(a_fill_max, clk, rst_n, fill_r <= CW'(alte_pkg::Depth), "fill count above depth")
  `ALTE_ASSERT_NEXT(a_start_idle, clk, rst_n, start, state_r == S_IDLE || $past(state_r) == S_IDLE, "start while not idle")
  `ALTE_ASSERT_NEXT(a_fin_idle, clk, rst_n, state_r == S_FIN, state_r == S_IDLE, "finish not followed by idle")
endmodule

@@ hdl/array_list_table_engine.sv @@
// top level of the array list table engine
//
// channel | direction | handshake           | contents
// in      | request   | in_tvalid/in_tready | mode, position, data_value, search_key
// out     | result    | out_tvalid/out_tready | result fields, see out_tdata
// cfg     | write     | cfg_we              | capacity
//
// one request at a time; the sequencer walks the entry ram one read at a time
// (address, then data); append, set and refused requests go straight from idle
// to finish, and the sorted check is the longest walk; the result register loads
// as the sequencer goes idle
// reset clears the fill count and loads capacity 10; entries are not cleared
// a finished result waits in the output register and holds off the next
// request until it is taken
`timescale 1ns / 1ps
module array_list_table_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[3:0], position[9:4], data_value[41:10], search_key[73:42], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted, found, result_index[7:2], result_value[39:8], total_sum[71:40],
  // largest[103:72], smallest[135:104], entry_count[142:136], in_order[143]
  output logic [alte_pkg::OutBytesW-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  logic [6:0] capacity_r;
  logic start, busy, done;
  alte_pkg::result_t res;
  logic out_valid_r;
  logic [alte_pkg::ResW-1:0] out_data_r;
  logic ram_we;
  logic [alte_pkg::IdxW-1:0] ram_waddr, ram_raddr;
  logic [alte_pkg::DataW-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= 7'd10;
    else if (cfg_we) capacity_r <= cfg_wdata;
  end

  // a waiting result blocks new requests so it cannot be overwritten
  assign in_tready = !busy && !out_valid_r;
  assign start = in_tvalid && in_tready;

  // output register, loaded when the sequencer finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = alte_pkg::OutBytesW'(out_data_r);

  alte_seq u_seq (
    .clk(clk), .rst_n(rst_n), .capacity(capacity_r),
    .start(start), .mode(in_tdata[3:0]), .position(in_tdata[9:4]),
    .data_value(in_tdata[41:10]), .search_key(in_tdata[73:42]),
    .busy(busy), .done(done), .result(res),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
  );

  alte_ram #(.AW(alte_pkg::IdxW), .DW(alte_pkg::DataW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule

@@ test/alte_checker.sv @@
// checker of the array list table engine: tracks the entry array and compares results
`timescale 1ns / 1ps
module alte_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [alte_pkg::OutBytesW-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  logic signed [31:0] arr [alte_pkg::Depth];
  int                 fill;
  int                 cap;
  alte_pkg::result_t  expected_q [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s after %0d results: got %h expected %h", what, result_count, got,
             want);
    fail_count++;
  endtask

  function automatic void swap_entries(input int a, input int b);
    logic signed [31:0] t;
    t = arr[a];
    arr[a] = arr[b];
    arr[b] = t;
  endfunction

  function automatic alte_pkg::result_t apply_request(input logic [79:0] req);
    alte_pkg::result_t r;
    logic [3:0] op;
    int pos, lim, i, j, lo, hi, mid;
    logic signed [31:0] dv, key, mx, mn;
    op  = req[3:0];
    pos = req[9:4];
    dv  = req[41:10];
    key = req[73:42];
    r   = '0;
    lim = (cap > alte_pkg::Depth) ? alte_pkg::Depth : cap;
    case (op)
      alte_pkg::OP_APPEND: if (fill < lim) begin
        arr[fill] = dv;
        fill++;
        r.accepted = 1;
      end
      alte_pkg::OP_INSERT: if (fill < lim && pos <= fill) begin
        for (i = fill; i > pos; i--) arr[i] = arr[i-1];
        arr[pos] = dv;
        fill++;
        r.accepted = 1;
      end
      alte_pkg::OP_DELETE: if (pos < fill) begin
        r.result_value = arr[pos];
        for (i = pos; i < fill - 1; i++) arr[i] = arr[i+1];
        fill--;
        r.accepted = 1;
      end
      alte_pkg::OP_GET: if (pos < fill) begin
        r.result_value = arr[pos];
        r.accepted = 1;
      end
      alte_pkg::OP_SET: if (pos < fill) begin
        arr[pos] = dv;
        r.accepted = 1;
      end
      alte_pkg::OP_LSEARCH: begin
        r.accepted = 1;
        for (i = 0; i < fill; i++) if (arr[i] == key) begin
          r.found = 1;
          r.result_index = alte_pkg::IdxW'(i);
          swap_entries(i, 0);
          break;
        end
      end
      alte_pkg::OP_SINSERT: if (fill < lim) begin
        i = fill - 1;
        while (i >= 0 && arr[i] > dv) begin
          arr[i+1] = arr[i];
          i--;
        end
        arr[i+1] = dv;
        fill++;
        r.accepted = 1;
      end
      alte_pkg::OP_BSEARCH: begin
        r.accepted = 1;
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (arr[mid] == key) begin
            r.found = 1;
            r.result_index = alte_pkg::IdxW'(mid);
            break;
          end else if (key < arr[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      alte_pkg::OP_STATS: if (fill > 0) begin
        mx = arr[0];
        mn = arr[0];
        for (i = 0; i < fill; i++) begin
          r.total_sum = r.total_sum + arr[i];
          if (arr[i] > mx) mx = arr[i];
          if (arr[i] < mn) mn = arr[i];
        end
        r.largest = mx;
        r.smallest = mn;
        r.accepted = 1;
      end
      alte_pkg::OP_REVERSE: begin
        for (i = 0, j = fill - 1; i < j; i++, j--) swap_entries(i, j);
        r.accepted = 1;
      end
      alte_pkg::OP_PART: begin
        i = 0;
        j = fill - 1;
        while (i < j) begin
          while (i < j && arr[i] < 0) i++;
          while (i < j && arr[j] >= 0) j--;
          if (i < j) swap_entries(i, j);
        end
        r.accepted = 1;
      end
      alte_pkg::OP_SORTED: begin
        r.in_order = 1;
        for (i = 0; i + 1 < fill; i++) if (arr[i] > arr[i+1]) begin
          r.in_order = 0;
          break;
        end
        r.accepted = 1;
      end
      default: ;
    endcase
    r.entry_count = alte_pkg::CntW'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    alte_pkg::result_t got, want;
    if (!rst_n) begin
      fill = 0;
      cap = 10;
      fail_count = 0;
      result_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) cap = cfg_wdata;
      if (in_tvalid && in_tready) expected_q.push_back(apply_request(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[alte_pkg::ResW-1:0];
        if (expected_q.size() == 0) begin
          $display("result with no request waiting");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
          if (got.found !== want.found) report("found", got.found, want.found);
          if (got.result_index !== want.result_index)
            report("result_index", got.result_index, want.result_index);
          if (got.result_value !== want.result_value)
            report("result_value", got.result_value, want.result_value);
          if (got.total_sum !== want.total_sum) report("total_sum", got.total_sum, want.total_sum);
          if (got.largest !== want.largest) report("largest", got.largest, want.largest);
          if (got.smallest !== want.smallest) report("smallest", got.smallest, want.smallest);
          if (got.entry_count !== want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
          if (got.in_order !== want.in_order) report("in_order", got.in_order, want.in_order);
        end
        result_count++;
      end
    end
    pending = expected_q.size();
  end
endmodule

@@ test/tb_array_list_table_engine.sv @@
// testbench top of the array list table engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_array_list_table_engine;
  localparam int IdleLimit = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [alte_pkg::OutBytesW-1:0] out_tdata;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = '0;
  int          fail_count, pending, result_count;
  int          idle_cycles = 0;
  int          request_count = 0;
  logic        stall_on = 1;
  int          stall_len = 0;

  always #1 clk = ~clk;

  array_list_table_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  alte_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // receiver: alternating runs of ready and stall, with stall-free stretches now and then
  always @(negedge clk) begin
    if (stall_len == 0) begin
      stall_on <= ~stall_on;
      stall_len <= stall_on ? $urandom_range(1, 12) : ($urandom_range(0, 3) == 0 ? 0 :
                   $urandom_range(1, 8));
      out_tready <= stall_on;
    end else begin
      stall_len <= stall_len - 1;
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("simulation failed");
      $finish;
    end
  end

  // one request, valid held until accepted; gap drops valid between requests
  task automatic send_request(input logic [3:0] op, input int pos, input logic [31:0] dv,
                              input logic [31:0] key, input int gap);
    in_tdata  <= {6'd0, key, dv, pos[5:0], op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    request_count++;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // pause until every expected result is back, plus drain margin
  task automatic drain;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_capacity(input int value);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= 7'(value);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // random value, skewed toward extremes and small numbers so searches hit
  function automatic logic [31:0] pick_value;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  initial begin
    int k, burst, op, cap_sel;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty-array cases, extremes, wrap of the sum, full array
    send_request(alte_pkg::OP_STATS, 0, 0, 0, 0);
    send_request(alte_pkg::OP_SORTED, 0, 0, 0, 0);
    send_request(alte_pkg::OP_DELETE, 0, 0, 0, 0);
    send_request(alte_pkg::OP_BSEARCH, 0, 0, 5, 0);
    send_request(alte_pkg::OP_APPEND, 0, 32'h7fff_ffff, 0, 0);
    send_request(alte_pkg::OP_APPEND, 0, 32'h7fff_ffff, 0, 0);
    send_request(alte_pkg::OP_INSERT, 0, 32'h8000_0000, 0, 0);
    send_request(alte_pkg::OP_INSERT, 63, 1, 0, 0);
    send_request(alte_pkg::OP_STATS, 0, 0, 0, 0);
    send_request(alte_pkg::OP_SINSERT, 0, 32'hffff_ffff, 0, 0);
    send_request(alte_pkg::OP_SET, 1, 32'hffff_ffff, 0, 0);
    send_request(alte_pkg::OP_GET, 1, 0, 0, 0);
    send_request(alte_pkg::OP_LSEARCH, 0, 0, 32'h7fff_ffff, 0);
    send_request(alte_pkg::OP_LSEARCH, 0, 0, 12345, 0);
    send_request(alte_pkg::OP_BSEARCH, 0, 0, 32'hffff_ffff, 0);
    send_request(alte_pkg::OP_REVERSE, 0, 0, 0, 0);
    send_request(alte_pkg::OP_PART, 0, 0, 0, 0);
    send_request(alte_pkg::OP_SORTED, 0, 0, 0, 0);
    send_request(4'd12, 63, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_request(4'd15, 0, 0, 0, 0);
    send_request(alte_pkg::OP_DELETE, 63, 0, 0, 0);
    send_request(alte_pkg::OP_DELETE, 0, 0, 0, 2);
    // capacity lowered below fill, then zero
    write_capacity(2);
    send_request(alte_pkg::OP_APPEND, 0, 7, 0, 0);
    write_capacity(0);
    send_request(alte_pkg::OP_SINSERT, 0, 7, 0, 0);
    write_capacity(64);

    // random phases under changing capacity, mostly small arrays
    for (int phase = 0; phase < 9; phase++) begin
      k = 0;
      while (k < 100) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && k < 100; b++, k++) begin
          op = $urandom_range(0, 15);
          if (op > 11 && $urandom_range(0, 3) != 0) op = $urandom_range(0, 6);
          send_request(4'(op), $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) :
                       $urandom_range(0, 12), pick_value(), pick_value(),
                       (b == burst - 1) ? $urandom_range(1, 20) : 0);
        end
      end
      cap_sel = $urandom_range(0, 4);
      write_capacity(phase == 4 ? 127 : cap_sel == 0 ? 1 : cap_sel == 1 ? 64 :
                     $urandom_range(3, 20));
    end

    drain();
    $display("%0d requests sent, %0d results checked across capacities 0 to 127",
             request_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
